>>> hw/rtl/stl_pkg.sv
`default_nettype none

package stl_pkg;

  localparam int unsigned CH_W         = 8;
  localparam int unsigned IN_TDATA_W   = 24;
  localparam int unsigned OUT_TDATA_W  = 16;
  localparam int unsigned LIN_W        = 17;
  localparam int unsigned PROD_W       = 32;
  localparam int unsigned SUM_W        = 33;
  localparam int unsigned Y_W          = 17;
  localparam int unsigned L_W          = 15;
  localparam int unsigned L_MAX        = 25600;

  localparam logic [15:0] W_RED        = 16'd13933;
  localparam logic [15:0] W_GREEN      = 16'd46871;
  localparam logic [15:0] W_BLUE       = 16'd4732;
  localparam logic [15:0] ROUND_Q16    = 16'd32768;

  localparam int unsigned SMALL_LIMIT  = (216 * 65536 + 24389 - 1) / 24389;
  localparam int unsigned LIN_Y_W      = 10;
  localparam int unsigned LIN_SLOPE    = 48778;
  localparam int unsigned LIN_BIAS     = 6912;
  localparam int unsigned LIN_DIV      = 13824;
  localparam int unsigned N_W          = 26;
  localparam int unsigned RECIP_SH     = 26;
  localparam int unsigned LIN_RECIP    = (1 << RECIP_SH) / LIN_DIV;
  localparam int unsigned RECIP_W      = 13;
  localparam int unsigned P_W          = N_W + RECIP_W;
  localparam int unsigned Q_W          = P_W - RECIP_SH;
  localparam int unsigned R_W          = N_W + 1;

  localparam int unsigned T_W          = 48;
  localparam longint unsigned CUBE_SCALE = 64'd928 * 64'd928 * 64'd928 * 64'd4;
  localparam int unsigned CBRT_BITS    = 15;
  localparam int unsigned L_OFFSET     = 4096;
  localparam int unsigned U_W          = 18;
  localparam int unsigned U2_W         = 32;
  localparam int unsigned U3_W         = 50;
  localparam int unsigned A_W          = 52;

  localparam int unsigned LUMA_STAGES  = 3;
  localparam int unsigned PRE_STAGES   = 3;
  localparam int unsigned NUM_STAGES   = LUMA_STAGES + PRE_STAGES + CBRT_BITS + 1;

  typedef logic [LIN_W-1:0] lin_table_t [2**CH_W];

  typedef struct packed {
    logic           dark;
    logic [Q_W-1:0] q;
  } side_t;

  // q16 linear value of one channel byte, rounded half up
  function automatic logic [LIN_W-1:0] lin_of(input int unsigned c);
    logic [255:0] rhs;
    logic [255:0] lhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    int unsigned  odd;
    int           i;
    if (c * 20000 <= 206295) begin
      lin_of = LIN_W'((c * 13107200 + 329460) / 658920);
    end else begin
      rhs = 256'd1;
      for (i = 0; i < 12; i++) begin
        rhs = rhs * 256'(40 * c + 561);
      end
      rhs = rhs << 85;
      lo = 0;
      hi = 65537;
      while (hi - lo > 1) begin
        mid = lo + ((hi - lo) >> 1);
        odd = 2 * mid - 1;
        lhs = 256'd1;
        for (i = 0; i < 5; i++) begin
          lhs = lhs * 256'(odd);
        end
        for (i = 0; i < 12; i++) begin
          lhs = lhs * 256'd10761;
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      lin_of = LIN_W'(lo);
    end
  endfunction

  function automatic lin_table_t build_lin_table();
    lin_table_t tbl;
    int         i;
    for (i = 0; i < 2**CH_W; i++) begin
      tbl[i] = lin_of(i);
    end
    return tbl;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

`default_nettype wire

>>> hw/rtl/stl_luma.sv
`default_nettype none

module stl_luma (
  input  logic                     clk,
  input  logic                     en,
  input  logic [stl_pkg::CH_W-1:0] red,
  input  logic [stl_pkg::CH_W-1:0] green,
  input  logic [stl_pkg::CH_W-1:0] blue,
  output logic [stl_pkg::Y_W-1:0]  luma
);
  import stl_pkg::*;

  logic [LIN_W-1:0]  lin_red_r;
  logic [LIN_W-1:0]  lin_green_r;
  logic [LIN_W-1:0]  lin_blue_r;
  logic [PROD_W-1:0] prod_red_r;
  logic [PROD_W-1:0] prod_green_r;
  logic [PROD_W-1:0] prod_blue_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [Y_W-1:0]    luma_r;

  always_comb begin
    sum_nxt = SUM_W'(prod_red_r) + SUM_W'(prod_green_r) + SUM_W'(prod_blue_r)
            + SUM_W'(ROUND_Q16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_red_r    <= LIN_TABLE[red];
      lin_green_r  <= LIN_TABLE[green];
      lin_blue_r   <= LIN_TABLE[blue];
      prod_red_r   <= PROD_W'(lin_red_r) * PROD_W'(W_RED);
      prod_green_r <= PROD_W'(lin_green_r) * PROD_W'(W_GREEN);
      prod_blue_r  <= PROD_W'(lin_blue_r) * PROD_W'(W_BLUE);
      luma_r       <= sum_nxt[SUM_W-1 -: Y_W];
    end
  end

  assign luma = luma_r;

endmodule

`default_nettype wire

>>> hw/rtl/stl_cbrt.sv
`default_nettype none

module stl_cbrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [stl_pkg::T_W-1:0]       target,
  input  stl_pkg::side_t                side_in,
  output logic [stl_pkg::CBRT_BITS-1:0] root,
  output stl_pkg::side_t                side_out
);
  import stl_pkg::*;

  // per stage: k, u = 2k-1, u^2, u^3
  logic        [CBRT_BITS-1:0] k_r   [CBRT_BITS];
  logic signed [U_W-1:0]       u_r   [CBRT_BITS];
  logic        [U2_W-1:0]      u2_r  [CBRT_BITS];
  logic signed [U3_W-1:0]      u3_r  [CBRT_BITS];
  logic        [T_W-1:0]       tgt_r [CBRT_BITS];
  side_t                       side_r[CBRT_BITS];

  for (genvar j = 0; j < CBRT_BITS; j++) begin : g_step
    localparam int B = CBRT_BITS - 1 - j;

    logic        [CBRT_BITS-1:0] k_in;
    logic signed [U_W-1:0]       u_in;
    logic        [U2_W-1:0]      u2_in;
    logic signed [U3_W-1:0]      u3_in;
    logic        [T_W-1:0]       t_in;
    side_t                       s_in;
    logic signed [U_W-1:0]       v;
    logic signed [A_W-1:0]       u_ext;
    logic signed [A_W-1:0]       u2_ext;
    logic signed [A_W-1:0]       v2;
    logic signed [A_W-1:0]       v3;
    logic                        take;

    if (j == 0) begin : g_first
      assign k_in  = '0;
      assign u_in  = '1;
      assign u2_in = U2_W'(1);
      assign u3_in = '1;
      assign t_in  = target;
      assign s_in  = side_in;
    end else begin : g_next
      assign k_in  = k_r[j-1];
      assign u_in  = u_r[j-1];
      assign u2_in = u2_r[j-1];
      assign u3_in = u3_r[j-1];
      assign t_in  = tgt_r[j-1];
      assign s_in  = side_r[j-1];
    end

    // try bit B of k: (u + d)^n with d = 2^(B+1), by shifts and adds
    always_comb begin
      u_ext  = A_W'(u_in);
      u2_ext = $signed(A_W'(u2_in));
      v      = u_in + $signed(U_W'(1) << (B + 1));
      v2     = u2_ext + (u_ext <<< (B + 2)) + (A_W'(1) <<< (2 * B + 2));
      v3     = A_W'(u3_in) + 3 * (u2_ext <<< (B + 1)) + 3 * (u_ext <<< (2 * B + 2))
             + (A_W'(1) <<< (3 * B + 3));
      take   = v3 <= $signed(A_W'(t_in));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (take) begin
          k_r[j]  <= k_in | (CBRT_BITS'(1) << B);
          u_r[j]  <= v;
          u2_r[j] <= v2[U2_W-1:0];
          u3_r[j] <= v3[U3_W-1:0];
        end else begin
          k_r[j]  <= k_in;
          u_r[j]  <= u_in;
          u2_r[j] <= u2_in;
          u3_r[j] <= u3_in;
        end
        tgt_r[j]  <= t_in;
        side_r[j] <= s_in;
      end
    end
  end

  assign root     = k_r[CBRT_BITS-1];
  assign side_out = side_r[CBRT_BITS-1];

endmodule

`default_nettype wire

>>> hw/rtl/stl_lstar.sv
`default_nettype none

module stl_lstar (
  input  logic                    clk,
  input  logic                    en,
  input  logic [stl_pkg::Y_W-1:0] luma,
  output logic [stl_pkg::L_W-1:0] lightness
);
  import stl_pkg::*;

  logic [T_W-1:0]       t4_r;
  logic [N_W-1:0]       n4_r;
  logic                 small4_r;
  logic [T_W-1:0]       t5_r;
  logic [N_W-1:0]       n5_r;
  logic [P_W-1:0]       p5_r;
  logic                 small5_r;
  logic [T_W-1:0]       t6_r;
  side_t                side6_r;
  logic [Q_W-1:0]       q_est;
  logic [R_W-1:0]       rem;
  side_t                side6_nxt;
  logic [CBRT_BITS-1:0] root;
  side_t                side_c;
  logic [L_W-1:0]       cube_l;
  logic [L_W-1:0]       lightness_nxt;
  logic [L_W-1:0]       lightness_r;

  // dark segment: floor((y*48778 + 6912) / 13824) by reciprocal and one correction
  always_comb begin
    q_est          = p5_r[P_W-1:RECIP_SH];
    rem            = R_W'(n5_r) - R_W'(q_est) * R_W'(LIN_DIV);
    side6_nxt.dark = small5_r;
    side6_nxt.q    = (rem >= R_W'(LIN_DIV)) ? q_est + Q_W'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_r     <= T_W'(luma) * T_W'(CUBE_SCALE);
      n4_r     <= N_W'(luma[LIN_Y_W-1:0]) * N_W'(LIN_SLOPE) + N_W'(LIN_BIAS);
      small4_r <= luma < Y_W'(SMALL_LIMIT);
      t5_r     <= t4_r;
      n5_r     <= n4_r;
      p5_r     <= P_W'(n4_r) * P_W'(LIN_RECIP);
      small5_r <= small4_r;
      t6_r     <= t5_r;
      side6_r  <= side6_nxt;
    end
  end

  stl_cbrt u_cbrt (
    .clk      (clk),
    .en       (en),
    .target   (t6_r),
    .side_in  (side6_r),
    .root     (root),
    .side_out (side_c)
  );

  always_comb begin
    if (root < CBRT_BITS'(L_OFFSET)) begin
      cube_l = '0;
    end else begin
      cube_l = L_W'(root - CBRT_BITS'(L_OFFSET));
    end
    lightness_nxt = side_c.dark ? L_W'(side_c.q) : cube_l;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lightness_r <= lightness_nxt;
    end
  end

  assign lightness = lightness_r;

endmodule

`default_nettype wire

>>> hw/rtl/srgb_to_cie_lightness.sv
// channel   dir  handshake          tdata fields (lsb first)
// in_       in   tvalid / tready    red [7:0], green [15:8], blue [23:16]
// out_      out  tvalid / tready    lightness [14:0], zero [15]
//
// one pixel per cycle sustained while the skid register is empty
// 22 pipeline stages: 3 for linearize and luminance, 3 for scaling and the dark
// segment divide, 15 for the bit-serial cube root search, 1 to select L*
// reset clears the valid bits and the output and skid flags only
// a stalled output parks one result in a skid register; the pipe holds while it is full
`default_nettype none

module srgb_to_cie_lightness (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [stl_pkg::IN_TDATA_W-1:0]      in_tdata,   // red, green, blue
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stl_pkg::OUT_TDATA_W-1:0]     out_tdata   // lightness, zero pad
);
  import stl_pkg::*;

  logic                  adv;
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [Y_W-1:0]        luma;
  logic [L_W-1:0]        res;
  logic                  push;
  logic                  pop;
  logic                  out_v_r;
  logic                  out_v_nxt;
  logic [L_W-1:0]        out_d_r;
  logic [L_W-1:0]        out_d_nxt;
  logic                  skid_v_r;
  logic                  skid_v_nxt;
  logic [L_W-1:0]        skid_d_r;
  logic [L_W-1:0]        skid_d_nxt;

  assign adv       = !skid_v_r;
  assign in_tready = adv;
  assign v_nxt     = {v_r[NUM_STAGES-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  stl_luma u_luma (
    .clk   (clk),
    .en    (adv),
    .red   (in_tdata[CH_W-1:0]),
    .green (in_tdata[2*CH_W-1:CH_W]),
    .blue  (in_tdata[3*CH_W-1:2*CH_W]),
    .luma  (luma)
  );

  stl_lstar u_lstar (
    .clk       (clk),
    .en        (adv),
    .luma      (luma),
    .lightness (res)
  );

  assign push = adv && v_r[NUM_STAGES-1];
  assign pop  = out_v_r && out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else begin
      if (pop) begin
        out_v_nxt = 1'b0;
      end
      if (push) begin
        if (!out_v_r || pop) begin
          out_v_nxt = 1'b1;
          out_d_nxt = res;
        end else begin
          skid_v_nxt = 1'b1;
          skid_d_nxt = res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'(out_d_r);

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_d_r <= L_W'(L_MAX))
    else $error("lightness beyond full scale");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready && v_r[NUM_STAGES-1] && !skid_v_r |=> skid_v_r)
    else $error("result leaving the pipe was not parked");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_tready |=> !skid_v_r)
    else $error("skid not drained after output beat");

endmodule

`default_nettype wire
